// File: src/sparse_matrix_vector_multiply_unit_macros.svh
// ----------------------------------------------------------------------------
// sparse matrix-vector multiply unit assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

`ifndef SYNTH
`define SMVM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SMVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SMVM_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SMVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: src/smvm_pkg.sv
// ----------------------------------------------------------------------------
// smvm_pkg
// shared types and constants of the sparse matrix-vector multiply unit
// ----------------------------------------------------------------------------
package smvm_pkg;

   localparam int IDX_W   = 10;
   localparam int VALUE_W = 32;
   localparam int PROD_W  = 64;
   localparam int ACC_W   = 48;
   localparam int FRAC_W  = 16;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_ENTRY = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic CSR_SYMMETRIC = 1'b0;
   localparam logic CSR_TRANSPOSE = 1'b1;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_XREAD,
      ST_MUL,
      ST_ACC,
      ST_YREAD,
      ST_YOUT
   } state_type;

endpackage

// File: src/smvm_ram.sv
// ----------------------------------------------------------------------------
// smvm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module smvm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sparse_matrix_vector_multiply_unit.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_unit
// streaming y = A*x or y = transpose(A)*x over (row, column, value) entries
//
// a request is taken when start is high and busy is low; busy stays high
// until the request is finished. req_mode selects: load x[row], coefficient
// entry (row, col, value), or read and clear y[row]. only a read gives a
// response: rsp_valid is high for one cycle with rsp_result_index and
// rsp_result_value in state ST_YOUT, after the y ram read in ST_YREAD. the
// receiver cannot stall it. one shared 32x32 multiplier and a 48-bit
// saturating adder do all the work, with one read-modify-write of the y ram
// per product term. a load writes x in ST_LOAD, a read passes ST_YREAD and
// ST_YOUT, an entry ST_XREAD, ST_MUL and ST_ACC (a symmetric entry off the
// diagonal twice, one term each through the y ram port); an unused mode or
// an entry out of range goes back to idle. csr writes (symmetric, transpose)
// are taken every cycle, csr_ready is high. reset clears the control
// registers and starts a y ram clearing pass, during which busy is high.
// ----------------------------------------------------------------------------
`include "sparse_matrix_vector_multiply_unit_macros.svh"

module sparse_matrix_vector_multiply_unit #(
   parameter int MAX_DIM = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_mode,
   input  logic [smvm_pkg::IDX_W-1:0]           req_row_index,
   input  logic [smvm_pkg::IDX_W-1:0]           req_col_index,
   input  logic signed [smvm_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   output logic [smvm_pkg::IDX_W-1:0]           rsp_result_index,
   output logic signed [smvm_pkg::ACC_W-1:0]    rsp_result_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic                                 csr_wdata
);

   localparam int AW = $clog2(MAX_DIM);
   localparam int IDX_W = smvm_pkg::IDX_W;
   localparam int VALUE_W = smvm_pkg::VALUE_W;
   localparam int PROD_W = smvm_pkg::PROD_W;
   localparam int ACC_W = smvm_pkg::ACC_W;
   localparam int FRAC_W = smvm_pkg::FRAC_W;

   smvm_pkg::state_type state_ff, state_in;

   logic                       symmetric_ff, symmetric_in;
   logic                       transpose_ff, transpose_in;
   logic [AW-1:0]              clr_cnt_ff, clr_cnt_in;
   logic                       second_ff, second_in;
   logic [IDX_W-1:0]           row_ff, row_in;
   logic [AW-1:0]              row_addr_ff, row_addr_in;
   logic [AW-1:0]              col_addr_ff, col_addr_in;
   logic                       in_range_ff, in_range_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic [AW-1:0]              dest_ff, dest_in;
   logic [AW-1:0]              src_ff, src_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   logic                       accept;
   logic                       row_ok;
   logic                       col_ok;
   logic [AW-1:0]              req_row_addr;
   logic [AW-1:0]              req_col_addr;

   logic                       x_wr_en;
   logic                       x_rd_en;
   logic [VALUE_W-1:0]         x_rd_data;
   logic                       y_wr_en;
   logic [AW-1:0]              y_wr_addr;
   logic [ACC_W-1:0]           y_wr_data;
   logic                       y_rd_en;
   logic [AW-1:0]              y_rd_addr;
   logic [ACC_W-1:0]           y_rd_data;

   logic signed [ACC_W-1:0]    term;
   logic signed [ACC_W:0]      sum;
   logic signed [ACC_W-1:0]    sum_sat;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign busy      = (state_ff != smvm_pkg::ST_IDLE);

   assign row_ok       = (32'(req_row_index) < 32'(MAX_DIM));
   assign col_ok       = (32'(req_col_index) < 32'(MAX_DIM));
   assign req_row_addr = AW'(32'(req_row_index));
   assign req_col_addr = AW'(32'(req_col_index));

   // floor rounding of the q32.32 product is an arithmetic shift
   assign term    = prod_ff[FRAC_W +: ACC_W];
   assign sum     = {y_rd_data[ACC_W-1], y_rd_data} + {term[ACC_W-1], term};
   always_comb begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sum_sat = sum[ACC_W] ? smvm_pkg::ACC_MIN : smvm_pkg::ACC_MAX;
      end else begin
         sum_sat = sum[ACC_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smvm_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == AW'(MAX_DIM - 1)) begin
               state_in = smvm_pkg::ST_IDLE;
            end
         end
         smvm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  smvm_pkg::MODE_LOAD:  state_in = smvm_pkg::ST_LOAD;
                  smvm_pkg::MODE_ENTRY: begin
                     state_in = (row_ok && col_ok) ? smvm_pkg::ST_XREAD
                                                   : smvm_pkg::ST_IDLE;
                  end
                  smvm_pkg::MODE_READ:  state_in = smvm_pkg::ST_YREAD;
                  default:              state_in = smvm_pkg::ST_IDLE;
               endcase
            end
         end
         smvm_pkg::ST_LOAD:  state_in = smvm_pkg::ST_IDLE;
         smvm_pkg::ST_XREAD: state_in = smvm_pkg::ST_MUL;
         smvm_pkg::ST_MUL:   state_in = smvm_pkg::ST_ACC;
         smvm_pkg::ST_ACC: begin
            state_in = second_ff ? smvm_pkg::ST_XREAD : smvm_pkg::ST_IDLE;
         end
         smvm_pkg::ST_YREAD: state_in = smvm_pkg::ST_YOUT;
         smvm_pkg::ST_YOUT:  state_in = smvm_pkg::ST_IDLE;
         default:            state_in = smvm_pkg::ST_IDLE;
      endcase
   end

   // datapath and ram controls
   always_comb begin
      symmetric_in = symmetric_ff;
      transpose_in = transpose_ff;
      clr_cnt_in   = clr_cnt_ff;
      second_in    = second_ff;
      row_in       = row_ff;
      row_addr_in  = row_addr_ff;
      col_addr_in  = col_addr_ff;
      in_range_in  = in_range_ff;
      value_in     = value_ff;
      dest_in      = dest_ff;
      src_in       = src_ff;
      prod_in      = prod_ff;
      x_wr_en      = 1'b0;
      x_rd_en      = 1'b0;
      y_wr_en      = 1'b0;
      y_wr_addr    = dest_ff;
      y_wr_data    = sum_sat;
      y_rd_en      = 1'b0;
      y_rd_addr    = dest_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            smvm_pkg::CSR_SYMMETRIC: symmetric_in = csr_wdata;
            smvm_pkg::CSR_TRANSPOSE: transpose_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         smvm_pkg::ST_CLEAR: begin
            y_wr_en    = 1'b1;
            y_wr_addr  = clr_cnt_ff;
            y_wr_data  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
         smvm_pkg::ST_IDLE: begin
            if (accept) begin
               row_in      = req_row_index;
               row_addr_in = req_row_addr;
               col_addr_in = req_col_addr;
               in_range_in = row_ok;
               value_in    = req_value;
               // transpose alone swaps the roles of row and column
               if (transpose_ff && !symmetric_ff) begin
                  dest_in = req_col_addr;
                  src_in  = req_row_addr;
               end else begin
                  dest_in = req_row_addr;
                  src_in  = req_col_addr;
               end
               second_in = symmetric_ff && (req_row_index != req_col_index);
            end
         end
         smvm_pkg::ST_LOAD: begin
            x_wr_en = in_range_ff;
         end
         smvm_pkg::ST_XREAD: begin
            x_rd_en   = 1'b1;
            y_rd_en   = 1'b1;
            y_rd_addr = dest_ff;
         end
         smvm_pkg::ST_MUL: begin
            prod_in = value_ff * $signed(x_rd_data);
         end
         smvm_pkg::ST_ACC: begin
            y_wr_en   = 1'b1;
            y_wr_addr = dest_ff;
            y_wr_data = sum_sat;
            if (second_ff) begin
               // mirrored term of a symmetric entry
               second_in = 1'b0;
               dest_in   = col_addr_ff;
               src_in    = row_addr_ff;
            end
         end
         smvm_pkg::ST_YREAD: begin
            y_rd_en   = 1'b1;
            y_rd_addr = row_addr_ff;
         end
         smvm_pkg::ST_YOUT: begin
            y_wr_en   = in_range_ff;
            y_wr_addr = row_addr_ff;
            y_wr_data = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smvm_pkg::ST_CLEAR;
         symmetric_ff <= 1'b0;
         transpose_ff <= 1'b0;
         clr_cnt_ff   <= '0;
         second_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         symmetric_ff <= symmetric_in;
         transpose_ff <= transpose_in;
         clr_cnt_ff   <= clr_cnt_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      row_addr_ff <= row_addr_in;
      col_addr_ff <= col_addr_in;
      in_range_ff <= in_range_in;
      value_ff    <= value_in;
      dest_ff     <= dest_in;
      src_ff      <= src_in;
      prod_ff     <= prod_in;
   end

   smvm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_DIM),
      .ADDR_W(AW)
   ) x_ram (
      .clock  (clock),
      .wr_en  (x_wr_en),
      .wr_addr(row_addr_ff),
      .wr_data(value_ff),
      .rd_en  (x_rd_en),
      .rd_addr(src_ff),
      .rd_data(x_rd_data)
   );

   smvm_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_DIM),
      .ADDR_W(AW)
   ) y_ram (
      .clock  (clock),
      .wr_en  (y_wr_en),
      .wr_addr(y_wr_addr),
      .wr_data(y_wr_data),
      .rd_en  (y_rd_en),
      .rd_addr(y_rd_addr),
      .rd_data(y_rd_data)
   );

   assign rsp_valid        = (state_ff == smvm_pkg::ST_YOUT);
   assign rsp_result_index = row_ff;
   assign rsp_result_value = in_range_ff ? $signed(y_rd_data) : '0;

   `SMVM_ASSERT_SAME(a_rsp_while_busy, clock, reset, rsp_valid, busy, "response outside request")
   `SMVM_ASSERT_NEXT(a_accept_busy, clock, reset, accept && (req_mode == smvm_pkg::MODE_LOAD || req_mode == smvm_pkg::MODE_READ), busy, "request taken but not busy")
   `SMVM_ASSERT_NEXT(a_single_rsp, clock, reset, rsp_valid, !rsp_valid, "response repeated")
   `SMVM_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, state_ff == smvm_pkg::ST_CLEAR, "no clearing pass after reset")

endmodule

// File: test/sparse_matrix_vector_multiply_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_unit_tb
// self-checking bench for the streaming spmv unit. a queue of requests and
// csr writes feeds a clocked driver; a clocked monitor keeps its own copy of
// the x store and the saturating y accumulators, predicts every read of y
// and compares each response field by field. a short directed part hits the
// extremes, rounding toward minus infinity, saturation both ways and the
// unused mode, then random phases run under every symmetric/transpose
// setting, with random gaps on the request side.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_unit_tb;

   localparam int         IDX_W        = smvm_pkg::IDX_W;
   localparam int         VALUE_W      = smvm_pkg::VALUE_W;
   localparam int         ACC_W        = smvm_pkg::ACC_W;
   localparam int         FRAC_W       = smvm_pkg::FRAC_W;
   localparam int         DIM          = 1024;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam int         HOT_N        = 16;
   localparam int         PHASES       = 6;
   localparam int         PHASE_ITEMS  = 175;
   localparam int         QUIET_CYCLES = 12;
   localparam int         GAP_PERCENT  = 29;

   typedef struct {
      bit                 is_csr;
      logic [1:0]         mode;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [VALUE_W-1:0] value;
      logic               csr_sel;
      logic               csr_bit;
   } pending_op_type;

   typedef struct {
      logic [IDX_W-1:0]        index;
      logic signed [ACC_W-1:0] value;
   } y_read_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_mode = smvm_pkg::MODE_LOAD;
   logic [IDX_W-1:0]           req_row_index = '0;
   logic [IDX_W-1:0]           req_col_index = '0;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic [IDX_W-1:0]           rsp_result_index;
   logic signed [ACC_W-1:0]    rsp_result_value;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic                       csr_index = smvm_pkg::CSR_SYMMETRIC;
   logic                       csr_wdata = 1'b0;

   pending_op_type             pending_ops[$];
   y_read_type                 expected_y_reads[$];

   logic signed [VALUE_W-1:0]  x_model [DIM];
   logic signed [ACC_W-1:0]    y_model [DIM];
   logic                       sym_mode = 1'b0;
   logic                       tr_mode = 1'b0;

   bit                         x_loaded [DIM];
   int                         loaded_list[$];
   int                         hot_idx [HOT_N];

   int                         mismatch_count = 0;
   int                         reqs_sent = 0;
   int                         reads_checked = 0;
   int                         saturated_reads = 0;
   int                         csr_writes = 0;
   int                         quiet = 0;

   sparse_matrix_vector_multiply_unit #(
      .MAX_DIM (DIM)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_index (rsp_result_index),
      .rsp_result_value (rsp_result_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("MISMATCH @%0t: %s", $time, msg);
      end
   endtask

   function automatic void accumulate_term(input logic [IDX_W-1:0] idx,
                                           input logic signed [VALUE_W-1:0] a,
                                           input logic signed [VALUE_W-1:0] xv);
      longint prod;
      longint sum;
      prod = longint'(a) * longint'(xv);
      sum  = longint'(y_model[idx]) + (prod >>> FRAC_W);
      if (sum > longint'(smvm_pkg::ACC_MAX)) begin
         sum = longint'(smvm_pkg::ACC_MAX);
      end else if (sum < longint'(smvm_pkg::ACC_MIN)) begin
         sum = longint'(smvm_pkg::ACC_MIN);
      end
      y_model[idx] = sum[ACC_W-1:0];
   endfunction

   function automatic void apply_spmv_request(input logic [1:0] mode,
                                              input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c,
                                              input logic signed [VALUE_W-1:0] a);
      y_read_type res;
      case (mode)
         smvm_pkg::MODE_LOAD: begin
            x_model[r] = a;
         end
         smvm_pkg::MODE_ENTRY: begin
            if (sym_mode) begin
               accumulate_term(r, a, x_model[c]);
               if (r != c) begin
                  accumulate_term(c, a, x_model[r]);
               end
            end else if (tr_mode) begin
               accumulate_term(c, a, x_model[r]);
            end else begin
               accumulate_term(r, a, x_model[c]);
            end
         end
         smvm_pkg::MODE_READ: begin
            res.index  = r;
            res.value  = y_model[r];
            y_model[r] = '0;
            expected_y_reads.push_back(res);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic bit take_gap();
      if (reqs_sent >= 350 && reqs_sent < 600) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < GAP_PERCENT;
   endfunction

   // driver
   always @(posedge clock) begin : driver
      pending_op_type op;
      bit             issued;
      issued = 1'b0;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         quiet     <= 0;
      end else begin
         if (start && !busy) begin
            quiet <= 0;
            reqs_sent++;
         end else if (quiet < 1000) begin
            quiet <= quiet + 1;
         end

         if (start && busy) begin
            issued = 1'b1;
         end else if (pending_ops.size() != 0 && !pending_ops[0].is_csr && !csr_valid
                      && !take_gap()) begin
            op            = pending_ops.pop_front();
            start         <= 1'b1;
            req_mode      <= op.mode;
            req_row_index <= op.row;
            req_col_index <= op.col;
            req_value     <= op.value;
            issued        = 1'b1;
         end else begin
            start <= 1'b0;
         end

         if (csr_valid && !csr_ready) begin
         end else if (!issued && !start && !busy && pending_ops.size() != 0
                      && pending_ops[0].is_csr && quiet >= QUIET_CYCLES
                      && expected_y_reads.size() == 0) begin
            op        = pending_ops.pop_front();
            csr_valid <= 1'b1;
            csr_index <= op.csr_sel;
            csr_wdata <= op.csr_bit;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin : monitor
      y_read_type exp_read;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_y_reads.size() == 0) begin
               report_mismatch($sformatf("response for y[%0d] with no read pending",
                                         rsp_result_index));
            end else begin
               exp_read = expected_y_reads.pop_front();
               reads_checked++;
               if (exp_read.value == smvm_pkg::ACC_MAX
                   || exp_read.value == smvm_pkg::ACC_MIN) begin
                  saturated_reads++;
               end
               if (rsp_result_index !== exp_read.index) begin
                  report_mismatch($sformatf("result_index %0d, expected %0d",
                                            rsp_result_index, exp_read.index));
               end
               if (rsp_result_value !== exp_read.value) begin
                  report_mismatch($sformatf("y[%0d] result_value %0d, expected %0d",
                                            exp_read.index, rsp_result_value,
                                            exp_read.value));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            csr_writes++;
            if (csr_index == smvm_pkg::CSR_SYMMETRIC) begin
               sym_mode = csr_wdata;
            end else begin
               tr_mode = csr_wdata;
            end
         end
         if (start && !busy) begin
            apply_spmv_request(req_mode, req_row_index, req_col_index, req_value);
         end
      end
   end

   task automatic push_req(input logic [1:0] mode, input int r, input int c,
                           input logic [VALUE_W-1:0] v);
      pending_op_type op;
      op.is_csr  = 1'b0;
      op.mode    = mode;
      op.row     = r[IDX_W-1:0];
      op.col     = c[IDX_W-1:0];
      op.value   = v;
      op.csr_sel = smvm_pkg::CSR_SYMMETRIC;
      op.csr_bit = 1'b0;
      pending_ops.push_back(op);
      if (mode == smvm_pkg::MODE_LOAD && !x_loaded[r]) begin
         x_loaded[r] = 1'b1;
         loaded_list.push_back(r);
      end
   endtask

   task automatic push_csr(input logic sel, input logic bit_val);
      pending_op_type op;
      op.is_csr  = 1'b1;
      op.mode    = smvm_pkg::MODE_LOAD;
      op.row     = '0;
      op.col     = '0;
      op.value   = '0;
      op.csr_sel = sel;
      op.csr_bit = bit_val;
      pending_ops.push_back(op);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return $urandom;
         default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      endcase
   endfunction

   // entries only touch x positions that were loaded
   function automatic int pick_loaded();
      if ($urandom_range(0, 99) < 85) begin
         return hot_idx[$urandom_range(0, HOT_N - 1)];
      end
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   function automatic int pick_any();
      if ($urandom_range(0, 99) < 65) begin
         return hot_idx[$urandom_range(0, HOT_N - 1)];
      end
      return $urandom_range(0, DIM - 1);
   endfunction

   initial begin : stimulus
      int   p;
      int   i;
      int   sel;
      int   guard;
      logic s;
      logic t;

      for (i = 0; i < DIM; i++) begin
         x_model[i]  = '0;
         y_model[i]  = '0;
         x_loaded[i] = 1'b0;
      end
      hot_idx[0] = 0;
      hot_idx[1] = DIM - 1;
      for (i = 2; i < HOT_N; i++) begin
         hot_idx[i] = $urandom_range(0, DIM - 1);
      end

      // directed part, registers at their reset value
      push_req(smvm_pkg::MODE_READ, 0, DIM - 1, 32'h7FFF_FFFF);
      push_req(smvm_pkg::MODE_READ, DIM - 1, 0, 32'h8000_0000);
      push_req(smvm_pkg::MODE_LOAD, 0, 0, 32'h7FFF_FFFF);
      push_req(smvm_pkg::MODE_LOAD, DIM - 1, DIM - 1, 32'h8000_0000);
      push_req(smvm_pkg::MODE_LOAD, 5, 0, 32'h8000_0000);
      push_req(smvm_pkg::MODE_ENTRY, 0, DIM - 1, 32'h0001_0000);
      for (i = 0; i < 3; i++) begin
         push_req(smvm_pkg::MODE_ENTRY, 5, 5, 32'h8000_0000);
      end
      push_req(smvm_pkg::MODE_READ, 5, 0, 32'h0);
      for (i = 0; i < 3; i++) begin
         push_req(smvm_pkg::MODE_ENTRY, DIM - 1, 0, 32'h8000_0000);
      end
      push_req(smvm_pkg::MODE_READ, DIM - 1, 0, 32'h0);
      push_req(smvm_pkg::MODE_LOAD, 3, 0, 32'h0000_0001);
      push_req(smvm_pkg::MODE_ENTRY, 3, 3, 32'hFFFF_FFFF);
      push_req(smvm_pkg::MODE_READ, 3, 0, 32'h0);
      push_req(MODE_UNUSED, 0, 0, 32'h7FFF_FFFF);
      push_req(smvm_pkg::MODE_READ, 0, DIM - 1, 32'hFFFF_FFFF);

      // random phases, one register setting each
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin s = 1'b0; t = 1'b1; end
            1:       begin s = 1'b1; t = 1'b0; end
            2:       begin s = 1'b1; t = 1'b1; end
            3:       begin s = 1'b0; t = 1'b0; end
            default: begin
               s = 1'($urandom_range(0, 1));
               t = 1'($urandom_range(0, 1));
            end
         endcase
         push_csr(smvm_pkg::CSR_SYMMETRIC, s);
         push_csr(smvm_pkg::CSR_TRANSPOSE, t);
         if (p == 0) begin
            for (i = 0; i < HOT_N; i++) begin
               push_req(smvm_pkg::MODE_LOAD, hot_idx[i], $urandom_range(0, DIM - 1),
                        pick_value());
            end
         end
         for (i = 0; i < PHASE_ITEMS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
               push_req(smvm_pkg::MODE_LOAD, pick_any(), $urandom_range(0, DIM - 1),
                        pick_value());
            end else if (sel < 75) begin
               push_req(smvm_pkg::MODE_ENTRY, pick_loaded(), pick_loaded(), pick_value());
            end else if (sel < 95) begin
               push_req(smvm_pkg::MODE_READ, pick_any(), $urandom_range(0, DIM - 1),
                        $urandom);
            end else begin
               push_req(MODE_UNUSED, $urandom_range(0, DIM - 1),
                        $urandom_range(0, DIM - 1), $urandom);
            end
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || start || csr_valid) begin
         @(posedge clock);
      end
      guard = 0;
      while (expected_y_reads.size() != 0 && guard < 200) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
      if (expected_y_reads.size() != 0) begin
         report_mismatch($sformatf("%0d reads never answered", expected_y_reads.size()));
      end

      $display("run covered %0d requests and %0d csr writes across %0d settings",
               reqs_sent, csr_writes, PHASES + 1);
      $display("%0d reads of y compared, %0d of them saturated, %0d mismatches",
               reads_checked, saturated_reads, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
